// ===== sv/tss_pkg.sv =====
// Shared constants and the control type for the Taylor series sine pipeline.
`default_nettype none

package tss_pkg;

	localparam int ANGLE_W     = 32;  // input angle width
	localparam int MAG_W       = 32;  // angle magnitude, holds 2^31
	localparam int SQ_W        = 2 * MAG_W;
	localparam int TERM_W      = 50;  // term magnitude, capped at 2^50 - 1
	localparam int RECIP_W     = 30;  // 1/((2i)(2i+1)) in Q0.32, i >= 1
	localparam int RECIP_SHIFT = 32;
	localparam int ACC_W       = 56;  // running sum, up to twelve terms
	localparam int OUT_W       = 40;
	localparam int CNT_W       = 4;
	localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 4'd5;

	typedef struct packed {
		logic             valid;
		logic             neg;     // sign of the angle
		logic [CNT_W-1:0] cnt;     // clamped term count
		logic             capped;  // some term magnitude hit its cap
	} tss_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tss_cell.sv =====
// One series cell: forms term TERM from the previous term; sums it if counted.
`default_nettype none

module tss_cell
	import tss_pkg::*;
#(
	parameter int TERM      = 1,
	parameter int FRAC_BITS = 28,
	parameter int X2_W      = 35
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire tss_ctl_t                 ctl_in,
	input  wire logic [TERM_W-1:0]        m_in,
	input  wire logic [X2_W-1:0]          x2_in,
	input  wire logic signed [ACC_W-1:0]  acc_in,
	output tss_ctl_t                      ctl_out,
	output logic [TERM_W-1:0]             m_out,
	output logic [X2_W-1:0]               x2_out,
	output logic signed [ACC_W-1:0]       acc_out
);

	localparam int ML_W   = TERM_W / 2;
	localparam int MH_W   = TERM_W - ML_W;
	localparam int XL_W   = (X2_W + 1) / 2;
	localparam int XH_W   = X2_W - XL_W;
	localparam int PROD_W = TERM_W + X2_W;
	localparam int Q_W    = TERM_W + RECIP_W;
	localparam longint unsigned DIV = 64'((2 * TERM) * (2 * TERM + 1));
	localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) + DIV / 2) / DIV;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam logic ODD = (TERM % 2) == 1;
	localparam logic [CNT_W-1:0] TERM_IDX = CNT_W'(TERM);

	tss_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [X2_W-1:0] x2_s1, x2_s2, x2_s3, x2_s4, x2_s5, x2_s6;
	logic signed [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4, acc_s5, acc_s6;
	logic [PROD_W-1:0] pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic [PROD_W-1:0] sum_a_s2, sum_b_s2;
	logic [TERM_W-1:0] p_s3;
	logic [Q_W-1:0]    q_lo_s4, q_hi_s4;
	logic [TERM_W-1:0] m_s5, m_s6;

	logic [ML_W+XL_W-1:0] pll;
	logic [ML_W+XH_W-1:0] plh;
	logic [MH_W+XL_W-1:0] phl;
	logic [MH_W+XH_W-1:0] phh;
	logic [PROD_W-1:0]    full;
	logic                 cap;
	logic [TERM_W-1:0]    p_next;
	logic [ML_W+RECIP_W-1:0] qlo;
	logic [MH_W+RECIP_W-1:0] qhi;
	logic [Q_W-1:0]       q_sum;
	logic [TERM_W-1:0]    m_next;
	logic signed [ACC_W-1:0] term_ext;
	logic                 tneg;
	logic                 cap_used;
	tss_ctl_t             ctl_cap;

	assign pll = m_in[ML_W-1:0] * x2_in[XL_W-1:0];
	assign plh = m_in[ML_W-1:0] * x2_in[X2_W-1:XL_W];
	assign phl = m_in[TERM_W-1:ML_W] * x2_in[XL_W-1:0];
	assign phh = m_in[TERM_W-1:ML_W] * x2_in[X2_W-1:XL_W];

	assign full   = sum_a_s2 + (sum_b_s2 << XL_W);
	assign cap    = |full[PROD_W-1:FRAC_BITS+TERM_W];
	assign p_next = cap ? {TERM_W{1'b1}} : full[FRAC_BITS +: TERM_W];
	// a capped step only counts when this term is part of the sum
	assign cap_used = cap && (ctl_s2.cnt > TERM_IDX);

	always_comb begin
		ctl_cap        = ctl_s2;
		ctl_cap.capped = ctl_s2.capped | cap_used;
	end

	assign qlo = p_s3[ML_W-1:0] * RECIP;
	assign qhi = p_s3[TERM_W-1:ML_W] * RECIP;

	assign q_sum  = q_lo_s4 + (q_hi_s4 << ML_W);
	assign m_next = TERM_W'(q_sum >> RECIP_SHIFT);

	assign term_ext = $signed({{(ACC_W-TERM_W){1'b0}}, m_s5});
	assign tneg     = ctl_s5.neg ^ ODD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_cap;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// partial products of term times x squared
			pp_ll_s1 <= PROD_W'(pll);
			pp_lh_s1 <= PROD_W'(plh);
			pp_hl_s1 <= PROD_W'(phl);
			pp_hh_s1 <= PROD_W'(phh);
			x2_s1    <= x2_in;
			acc_s1   <= acc_in;

			sum_a_s2 <= pp_ll_s1 + (pp_hl_s1 << ML_W);
			sum_b_s2 <= pp_lh_s1 + (pp_hh_s1 << ML_W);
			x2_s2    <= x2_s1;
			acc_s2   <= acc_s1;

			p_s3     <= p_next;
			x2_s3    <= x2_s2;
			acc_s3   <= acc_s2;

			// partial products of the scaled term times the reciprocal
			q_lo_s4  <= Q_W'(qlo);
			q_hi_s4  <= Q_W'(qhi);
			x2_s4    <= x2_s3;
			acc_s4   <= acc_s3;

			m_s5     <= m_next;
			x2_s5    <= x2_s4;
			acc_s5   <= acc_s4;

			m_s6     <= m_s5;
			x2_s6    <= x2_s5;
			if (ctl_s5.cnt > TERM_IDX) begin
				acc_s6 <= tneg ? (acc_s5 - term_ext) : (acc_s5 + term_ext);
			end else begin
				acc_s6 <= acc_s5;
			end
		end
	end

	assign ctl_out = ctl_s6;
	assign m_out   = m_s6;
	assign x2_out  = x2_s6;
	assign acc_out = acc_s6;

endmodule

`default_nettype wire

// ===== sv/taylor_series_sine_unit.sv =====
// Taylor series sine: head stages, chain of term cells, clip and output buffering.
//
// Usage:
//   s_axis carries one angle per transaction (Q3.28 radians, signed 32 bits).
//   m_axis returns one result per angle, in order: the series sum, clipped to
//   a signed 40-bit value, and a flag set when clipping happened or a term
//   magnitude hit its cap.
//   cfg_valid/cfg_data write the term count (1..MAX_TERMS; 0 acts as 1, larger
//   values act as MAX_TERMS). cfg_ready is always high. Write it while idle.
// Throughput: one angle per cycle while m_axis_tready stays high.
// Pipeline: head stages, then one cell per term after the first, then the
//   output register; each cell performs its two split multiplies and the sum
//   update, independent of the term count.
// Reset: clears every valid bit and loads a term count of 5.
// Stall: a stalled result sits in the output register; the next finished
//   result goes to a skid register, and while that is full s_axis_tready
//   is low and the whole chain holds.
`default_nettype none

module taylor_series_sine_unit
	import tss_pkg::*;
#(
	parameter int MAX_TERMS = 8,
	parameter int FRAC_BITS = 28
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [ANGLE_W-1:0] s_axis_tdata,  // [31:0] angle
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [OUT_W-1:0]        m_axis_tdata,  // [39:0] sine_value
	output logic [0:0]              m_axis_tuser,  // [0] saturated
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CNT_W-1:0]   cfg_data       // [3:0] term_count
);

	localparam int X2_W = SQ_W - 1 - FRAC_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

	logic [CNT_W-1:0] term_count_q;
	logic en;

	tss_ctl_t ctl_s1, ctl_s2;
	logic [MAG_W-1:0] mag_s1, mag_s2;
	logic [SQ_W-1:0]  sq_s2;
	logic signed [ACC_W-1:0] acc_s1, acc_s2;

	logic [MAG_W-1:0] mag_in;
	logic             neg_in;
	logic [CNT_W-1:0] cnt_in;

	tss_ctl_t                 link_ctl [MAX_TERMS];
	logic [TERM_W-1:0]        link_m   [MAX_TERMS];
	logic [X2_W-1:0]          link_x2  [MAX_TERMS];
	logic signed [ACC_W-1:0]  link_acc [MAX_TERMS];

	logic                     tail_valid;
	logic signed [ACC_W-1:0]  tail_acc;
	logic                     fits;
	logic [OUT_W-1:0]         res_value;
	logic                     res_sat;

	logic             out_valid_q, skid_valid_q;
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic             out_sat_q, skid_sat_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			term_count_q <= cfg_data;
		end
	end

	// head: magnitude, sign, clamped count, x squared
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign neg_in        = s_axis_tdata[ANGLE_W-1];
	assign mag_in        = neg_in ? (~s_axis_tdata + 1'b1) : s_axis_tdata;

	always_comb begin
		cnt_in = term_count_q;
		if (term_count_q == '0) begin
			cnt_in = CNT_W'(1);
		end else if (term_count_q > CNT_MAX) begin
			cnt_in = CNT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= s_axis_tvalid;
			ctl_s1.neg    <= neg_in;
			ctl_s1.cnt    <= cnt_in;
			ctl_s1.capped <= 1'b0;
			ctl_s2        <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			acc_s1 <= neg_in ? -$signed({{(ACC_W-MAG_W){1'b0}}, mag_in})
			                 :  $signed({{(ACC_W-MAG_W){1'b0}}, mag_in});
			sq_s2  <= mag_s1 * mag_s1;
			mag_s2 <= mag_s1;
			acc_s2 <= acc_s1;
		end
	end

	// the term magnitude for cell 1 is the angle magnitude itself
	assign link_ctl[0] = ctl_s2;
	assign link_m[0]   = TERM_W'(mag_s2);
	assign link_x2[0]  = sq_s2[FRAC_BITS +: X2_W];
	assign link_acc[0] = acc_s2;

	// chain of cells, one per term after the first
	for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
		tss_cell #(
			.TERM      (k),
			.FRAC_BITS (FRAC_BITS),
			.X2_W      (X2_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (link_ctl[k-1]),
			.m_in    (link_m[k-1]),
			.x2_in   (link_x2[k-1]),
			.acc_in  (link_acc[k-1]),
			.ctl_out (link_ctl[k]),
			.m_out   (link_m[k]),
			.x2_out  (link_x2[k]),
			.acc_out (link_acc[k])
		);
	end

	// tail: clip to the output range
	assign tail_valid = link_ctl[MAX_TERMS-1].valid;
	assign tail_acc   = link_acc[MAX_TERMS-1];
	assign fits = (&tail_acc[ACC_W-1:OUT_W-1]) || !(|tail_acc[ACC_W-1:OUT_W-1]);

	always_comb begin
		if (fits) begin
			res_value = tail_acc[OUT_W-1:0];
		end else if (tail_acc[ACC_W-1]) begin
			res_value = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			res_value = {1'b0, {(OUT_W-1){1'b1}}};
		end
		res_sat = !fits || link_ctl[MAX_TERMS-1].capped;
	end

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (tail_valid && out_valid_q && !m_axis_tready) begin
			skid_valid_q <= 1'b1;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= tail_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
				out_sat_q  <= skid_sat_q;
			end
		end else if (tail_valid && out_valid_q && !m_axis_tready) begin
			skid_data_q <= res_value;
			skid_sat_q  <= res_sat;
		end else if (!out_valid_q || m_axis_tready) begin
			out_data_q <= res_value;
			out_sat_q  <= res_sat;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_sat_q;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_axis_tvalid)
		else $error("skid register full while output register empty");

	a_skid_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tail_valid && m_axis_tvalid && !m_axis_tready) |=> skid_valid_q)
		else $error("finished result not caught by skid register");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("skid register filled without an output stall");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> (ctl_s1.cnt != '0 && ctl_s1.cnt <= CNT_MAX))
		else $error("term count outside 1..MAX_TERMS entered the chain");

endmodule

`default_nettype wire

// ===== sim/tb_taylor_series_sine_unit.sv =====
// Self-checking testbench for the Taylor series sine unit: directed table, then random angles.
module tb_taylor_series_sine_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tss_pkg::*;

	localparam int MAX_TERMS      = 8;
	localparam int FRAC_BITS      = 28;
	localparam int CLK_PERIOD     = 12;
	localparam int LATENCY        = 2 + 6 * (MAX_TERMS - 1) + 1;
	localparam int LONG_STALL     = 4 * LATENCY;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SEGMENT_ITEMS  = 255;
	localparam logic [127:0] TERM_LIMIT = (128'd1 << 50) - 128'd1;
	localparam logic signed [63:0] SUM_HI = 64'sd549755813887;
	localparam logic signed [63:0] SUM_LO = -64'sd549755813888;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             sat;
	} sine_result_t;

	typedef struct {
		logic [CNT_W-1:0]   count;
		logic [ANGLE_W-1:0] angle;
		bit                 typed;
		sine_result_t       result;
	} directed_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [ANGLE_W-1:0] s_axis_tdata = '0;  // [31:0] angle
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;       // [39:0] sine_value
	logic [0:0]         m_axis_tuser;       // [0] saturated
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data = '0;      // [3:0] term_count

	sine_result_t  sine_expected[$];
	directed_row_t directed_rows[$];
	logic [CNT_W-1:0] model_term_count = TERM_COUNT_RESET;

	// Expectation that travels with the angle currently on s_axis
	bit           drv_typed = 1'b0;
	sine_result_t drv_result = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int send_burst = 0;
	int recv_burst = 0;
	bit stall_request = 1'b0;
	int stall_left = 0;

	int error_count = 0;
	int angles_accepted = 0;
	int results_checked = 0;
	int idle_cycles = 0;
	logic [15:0] counts_used = '0;

	taylor_series_sine_unit #(
		.MAX_TERMS(MAX_TERMS),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// (a*b) >> sh on magnitudes, held at the term cap
	function automatic logic [63:0] mul_shift_capped(input logic [63:0] a, input logic [63:0] b,
			input int sh, inout logic capped);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> sh;
		if (prod > TERM_LIMIT) begin
			capped = 1'b1;
			return TERM_LIMIT[63:0];
		end
		return prod[63:0];
	endfunction

	function automatic sine_result_t predict_sine(input logic [ANGLE_W-1:0] angle,
			input logic [CNT_W-1:0] count);
		logic               neg;
		logic               capped;
		logic               term_neg;
		logic [63:0]        mag, x2, m, p, d, recip;
		logic signed [63:0] acc;
		int                 n;
		sine_result_t       r;
		neg = angle[ANGLE_W-1];
		mag = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
		if (count == 0)
			n = 1;
		else if (count > MAX_TERMS)
			n = MAX_TERMS;
		else
			n = count;
		capped = 1'b0;
		x2 = mul_shift_capped(mag, mag, FRAC_BITS, capped);
		m = mag;
		acc = neg ? -$signed(m) : $signed(m);
		for (int i = 1; i < n; i++) begin
			d = 64'(2 * i * (2 * i + 1));
			recip = ((64'd1 << 32) + d / 2) / d;
			p = mul_shift_capped(m, x2, FRAC_BITS, capped);
			m = mul_shift_capped(p, recip, 32, capped);
			term_neg = neg ^ (i % 2 == 1);
			acc = term_neg ? acc - $signed(m) : acc + $signed(m);
		end
		r.sat = capped;
		if (acc > SUM_HI) begin
			acc = SUM_HI;
			r.sat = 1'b1;
		end else if (acc < SUM_LO) begin
			acc = SUM_LO;
			r.sat = 1'b1;
		end
		r.value = acc[OUT_W-1:0];
		return r;
	endfunction

	function automatic bit take_gap(input int pct, inout int burst);
		if (pct == 0)
			return 1'b0;
		if (burst > 0) begin
			burst--;
			return 1'b0;
		end
		// now and then run a stretch without gaps
		if ($urandom_range(0, 99) < 4) begin
			burst = $urandom_range(10, 40);
			return 1'b0;
		end
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [ANGLE_W-1:0] random_angle();
		int                 pick;
		logic [ANGLE_W-1:0] a;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			a = $urandom();
		else if (pick < 8)
			a = $urandom_range(0, 32'h3243_F6A8);
		else if (pick == 8)
			a = $urandom_range(0, 1000);
		else
			a = 32'h7FFF_FFFF - $urandom_range(0, 1000);
		if (pick >= 6 && $urandom_range(0, 1) == 1)
			a = -a;
		return a;
	endfunction

	function automatic void add_row(input logic [CNT_W-1:0] count, input logic [ANGLE_W-1:0] angle,
			input bit typed = 1'b0, input logic [OUT_W-1:0] value = '0);
		directed_row_t row;
		row.count = count;
		row.angle = angle;
		row.typed = typed;
		row.result = '{value: value, sat: 1'b0};
		directed_rows.push_back(row);
	endfunction

	task automatic send_angle(input logic [ANGLE_W-1:0] angle, input bit typed,
			input sine_result_t result);
		@(negedge clk);
		while (take_gap(send_idle_pct, send_burst)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= angle;
		drv_typed = typed;
		drv_result = result;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Drain the pipeline, then write the term count
	task automatic write_term_count(input logic [CNT_W-1:0] count);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sine_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_request) begin
			stall_request = 1'b0;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !take_gap(recv_idle_pct, recv_burst);
		end
	end

	always @(posedge clk) begin
		sine_result_t want;
		if (cfg_valid && cfg_ready)
			model_term_count = cfg_data;
		if (s_axis_tvalid && s_axis_tready) begin
			if (drv_typed)
				sine_expected.push_back(drv_result);
			else
				sine_expected.push_back(predict_sine(s_axis_tdata, model_term_count));
			counts_used[model_term_count] = 1'b1;
			angles_accepted++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (sine_expected.size() == 0) begin
				$error("unexpected result transaction: sine_value %h saturated %b",
					m_axis_tdata, m_axis_tuser[0]);
				error_count++;
			end else begin
				want = sine_expected.pop_front();
				results_checked++;
				if (m_axis_tdata !== want.value) begin
					$error("sine_value: expected %h, got %h", want.value, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tuser[0] !== want.sat) begin
					$error("saturated: expected %b, got %b", want.sat, m_axis_tuser[0]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d results pending",
				idle_cycles, sine_expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] current_count;
		logic [CNT_W-1:0] seg_count;
		int               idle_modes[3][2];
		idle_modes = '{'{38, 67}, '{67, 38}, '{0, 0}};

		// Directed table; typed expectations where the sum is plain to see
		add_row(4'd5, 32'h0000_0000, 1'b1, 40'h00_0000_0000);
		add_row(4'd5, 32'h0000_0001);
		add_row(4'd5, 32'hFFFF_FFFF);
		add_row(4'd5, 32'h7FFF_FFFF);
		add_row(4'd5, 32'h8000_0000);
		add_row(4'd5, 32'h1000_0000);
		add_row(4'd5, 32'hF000_0000);
		// zero acts as one term: the angle comes back sign-extended
		add_row(4'd0, 32'h7FFF_FFFF, 1'b1, 40'h00_7FFF_FFFF);
		add_row(4'd0, 32'h8000_0000, 1'b1, 40'hFF_8000_0000);
		add_row(4'd0, 32'h0000_0000, 1'b1, 40'h00_0000_0000);
		add_row(4'd1, 32'h1234_5678, 1'b1, 40'h00_1234_5678);
		add_row(4'd1, 32'hFFFF_FFFF, 1'b1, 40'hFF_FFFF_FFFF);
		add_row(4'd8, 32'h7FFF_FFFF);
		add_row(4'd8, 32'h8000_0000);
		add_row(4'd8, 32'h3243_F6A8);
		add_row(4'd8, 32'hCDBC_0958);
		add_row(4'd8, 32'h0000_0000, 1'b1, 40'h00_0000_0000);
		// above the maximum acts as the maximum
		add_row(4'd15, 32'h7FFF_FFFF);
		add_row(4'd15, 32'h8000_0000);
		add_row(4'd15, 32'h5555_5555);
		add_row(4'd15, 32'hAAAA_AAAA);
		add_row(4'd15, 32'h0000_0000, 1'b1, 40'h00_0000_0000);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		current_count = TERM_COUNT_RESET;
		foreach (directed_rows[k]) begin
			if (directed_rows[k].count != current_count) begin
				write_term_count(directed_rows[k].count);
				current_count = directed_rows[k].count;
			end
			send_angle(directed_rows[k].angle, directed_rows[k].typed, directed_rows[k].result);
		end

		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 0)
				seg_count = 4'd8;
			else if (seg == 1)
				seg_count = 4'd1;
			else
				seg_count = CNT_W'($urandom_range(0, 15));
			write_term_count(seg_count);
			send_idle_pct = idle_modes[seg / 2][0];
			recv_idle_pct = idle_modes[seg / 2][1];
			// hold the result side off long enough for the chain to back up
			if (seg == 4)
				stall_request = 1'b1;
			for (int k = 0; k < SEGMENT_ITEMS; k++)
				send_angle(random_angle(), 1'b0, '0);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sine_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sine_expected.size() != 0) begin
			$error("%0d expected results never arrived", sine_expected.size());
			error_count++;
		end

		$display("Checked %0d results for %0d angles, directed extremes plus random angles,",
			results_checked, angles_accepted);
		$display("term counts used (bit per count): %b, with idle, stall and back-pressure phases",
			counts_used);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tss_pkg.sv
sv/tss_cell.sv
sv/taylor_series_sine_unit.sv
sim/tb_taylor_series_sine_unit.sv
